>>> rtl/sc2a_pkg.sv
// package: payload types, key codes and scancode lookup table for the scancode decoder
`timescale 1ns / 1ps
`default_nettype none
package sc2a_pkg;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_CTRL   = 7'h1D;
  localparam logic [6:0] KEY_ALT    = 7'h38;
  localparam logic [6:0] KEY_PREFIX = 7'h60;
  localparam logic [6:0] KEY_LMETA  = 7'h5B;
  localparam logic [6:0] KEY_RMETA  = 7'h5C;

  localparam logic [7:0] CHAR_NONE = 8'h00;
  localparam logic [7:0] CHAR_DEL  = 8'h7F;

  typedef struct packed {
    logic       opcode;
    logic [7:0] scancode;
  } cmd_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_byte;
    logic       overflow;
    logic       reset_request;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
  } rsp_t;

  typedef struct packed {
    logic char_valid;
    logic overflow;
    logic reset_request;
    logic shift_held;
    logic ctrl_held;
    logic alt_held;
  } stage_t;

  // {shifted, unshifted} character for a key code
  function automatic logic [15:0] key_pair(input logic [6:0] code);
    logic [15:0] pair;
    case (code)
      7'h1E: pair = 16'h4161;
      7'h30: pair = 16'h4262;
      7'h2E: pair = 16'h4363;
      7'h20: pair = 16'h4464;
      7'h12: pair = 16'h4565;
      7'h21: pair = 16'h4666;
      7'h22: pair = 16'h4767;
      7'h23: pair = 16'h4868;
      7'h17: pair = 16'h4969;
      7'h24: pair = 16'h4A6A;
      7'h25: pair = 16'h4B6B;
      7'h26: pair = 16'h4C6C;
      7'h32: pair = 16'h4D6D;
      7'h31: pair = 16'h4E6E;
      7'h18: pair = 16'h4F6F;
      7'h19: pair = 16'h5070;
      7'h10: pair = 16'h5171;
      7'h13: pair = 16'h5272;
      7'h1F: pair = 16'h5373;
      7'h14: pair = 16'h5474;
      7'h16: pair = 16'h5575;
      7'h2F: pair = 16'h5676;
      7'h11: pair = 16'h5777;
      7'h2D: pair = 16'h5878;
      7'h15: pair = 16'h5979;
      7'h2C: pair = 16'h5A7A;
      7'h39: pair = 16'h2020;
      7'h02: pair = 16'h2131;
      7'h03: pair = 16'h2232;
      7'h04: pair = 16'h2333;
      7'h05: pair = 16'h2434;
      7'h06: pair = 16'h2535;
      7'h07: pair = 16'h2636;
      7'h08: pair = 16'h2F37;
      7'h09: pair = 16'h2838;
      7'h0A: pair = 16'h2939;
      7'h0B: pair = 16'h3D30;
      7'h0E: pair = 16'h0808;
      7'h0F: pair = 16'h0909;
      7'h1C: pair = 16'h0A0A;
      7'h01: pair = 16'h1B1B;
      7'h2B: pair = 16'h2727;
      7'h33: pair = 16'h3B2C;
      7'h34: pair = 16'h3A2E;
      7'h35: pair = 16'h5F2D;
      7'h28: pair = 16'h2727;
      7'h53: pair = 16'h7F7F;
      default: pair = 16'h0000;
    endcase
    return pair;
  endfunction

endpackage
`default_nettype wire

>>> rtl/sc2a_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module sc2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/sc2a_ctrl.sv
// modifier flags, key lookup and character fifo control around the ram
`timescale 1ns / 1ps
`default_nettype none
module sc2a_ctrl #(
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire sc2a_pkg::cmd_t item,
  output sc2a_pkg::rsp_t     result
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(FIFO_DEPTH);

  logic shift_flag, ctrl_flag, alt_flag;
  logic shift_next, ctrl_next, alt_next;
  logic [AW-1:0] read_pointer, write_pointer;
  logic [CW-1:0] fill_count;
  sc2a_pkg::stage_t stage;

  logic [6:0]  code;
  logic        pressed;
  logic        is_scan, is_read, is_mod;
  logic [15:0] pair;
  logic [7:0]  ch;
  logic        want_push, push, pop, ovf, rst_req;
  logic [7:0]  rd_data;

  assign code    = item.scancode[6:0];
  assign pressed = ~item.scancode[7];
  assign is_scan = accept && (item.opcode == sc2a_pkg::OP_SCAN);
  assign is_read = accept && (item.opcode == sc2a_pkg::OP_READ);
  assign pair    = sc2a_pkg::key_pair(code);
  assign ch      = shift_flag ? pair[15:8] : pair[7:0];

  always_comb begin
    shift_next = shift_flag;
    ctrl_next  = ctrl_flag;
    alt_next   = alt_flag;
    is_mod     = 1'b1;
    case (code)
      sc2a_pkg::KEY_LSHIFT, sc2a_pkg::KEY_RSHIFT: shift_next = pressed;
      sc2a_pkg::KEY_CTRL:   ctrl_next = pressed;
      sc2a_pkg::KEY_ALT:    alt_next  = pressed;
      sc2a_pkg::KEY_PREFIX, sc2a_pkg::KEY_LMETA, sc2a_pkg::KEY_RMETA: is_mod = 1'b1;
      default:              is_mod = 1'b0;
    endcase
  end

  assign rst_req   = is_scan && !is_mod && (ch == sc2a_pkg::CHAR_DEL) && ctrl_flag && alt_flag;
  assign want_push = is_scan && !is_mod && (ch != sc2a_pkg::CHAR_NONE) && pressed;
  assign push      = want_push && (fill_count != FULL);
  assign ovf       = want_push && (fill_count == FULL);
  assign pop       = is_read && (fill_count != '0);

  sc2a_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (push),
    .wr_addr(write_pointer),
    .wr_data(ch),
    .rd_en  (pop),
    .rd_addr(read_pointer),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_flag    <= 1'b0;
      ctrl_flag     <= 1'b0;
      alt_flag      <= 1'b0;
      read_pointer  <= '0;
      write_pointer <= '0;
      fill_count    <= '0;
    end else begin
      if (is_scan) begin
        shift_flag <= shift_next;
        ctrl_flag  <= ctrl_next;
        alt_flag   <= alt_next;
      end
      if (push) begin
        write_pointer <= (write_pointer == LAST) ? '0 : write_pointer + 1'b1;
        fill_count    <= fill_count + 1'b1;
      end
      if (pop) begin
        read_pointer <= (read_pointer == LAST) ? '0 : read_pointer + 1'b1;
        fill_count   <= fill_count - 1'b1;
      end
    end
  end

  // result fields wait here while the ram read is in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      stage.char_valid    <= pop;
      stage.overflow      <= ovf;
      stage.reset_request <= rst_req;
      stage.shift_held    <= is_scan ? shift_next : shift_flag;
      stage.ctrl_held     <= is_scan ? ctrl_next : ctrl_flag;
      stage.alt_held      <= is_scan ? alt_next : alt_flag;
    end
  end

  always_comb begin
    result.char_valid    = stage.char_valid;
    result.char_byte     = stage.char_valid ? rd_data : sc2a_pkg::CHAR_NONE;
    result.overflow      = stage.overflow;
    result.reset_request = stage.reset_request;
    result.shift_held    = stage.shift_held;
    result.ctrl_held     = stage.ctrl_held;
    result.alt_held      = stage.alt_held;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) fill_count <= FULL)
    else $error("fifo fill count above depth");
  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst) !(push && pop))
    else $error("push and pop in one cycle");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push |=> fill_count == $past(fill_count) + 1'b1)
    else $error("push did not raise fill count");

endmodule
`default_nettype wire

>>> rtl/scancode_to_ascii_with_fifo.sv
// top level: set-1 scancode decoder with character fifo and output skid register
// path: a beat's result waits in the stage register during the ram read, then moves to the output register
// throughput: one beat per cycle; input stalls only when both result stages hold beats
//   and the output is stalled
// reset: clears modifier flags, fifo pointers, fill count and stage valid bits
// the character ram is not cleared; the fill count keeps reads on written entries
`timescale 1ns / 1ps
`default_nettype none
module scancode_to_ascii_with_fifo #(
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire sc2a_pkg::cmd_t cmd,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output sc2a_pkg::rsp_t      rsp
);

  logic           s1_valid;
  logic           accept, advance;
  sc2a_pkg::rsp_t result;

  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = s1_valid && rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  sc2a_ctrl #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (cmd),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  a_advance_out: assert property (@(posedge clk) disable iff (rst) advance |=> rsp_valid)
    else $error("beat lost between stages");
  a_read_no_ovf: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.char_valid |-> !rsp.overflow && !rsp.reset_request)
    else $error("read beat carries scancode status");
  a_empty_byte: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.char_valid |-> rsp.char_byte == sc2a_pkg::CHAR_NONE)
    else $error("byte without character");

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// testbench for the scancode decoder: self-checking against its own key map and fifo model
`timescale 1ns / 1ps
module tb_top;

  localparam int FIFO_DEPTH  = 64;
  localparam int HOLD_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  sc2a_pkg::cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  sc2a_pkg::rsp_t rsp;

  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  logic hold_active = 1'b0;

  scancode_to_ascii_with_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  class keymap_tracker;
    logic shift_on, ctrl_on, alt_on, lmeta_on, rmeta_on;
    logic [7:0] typed_chars[$];
    sc2a_pkg::rsp_t pending_rsp[$];
    int errors;

    function new();
      shift_on = 1'b0;
      ctrl_on = 1'b0;
      alt_on = 1'b0;
      lmeta_on = 1'b0;
      rmeta_on = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction

    function logic [7:0] char_of(input logic [6:0] code, input logic shifted);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = sc2a_pkg::CHAR_NONE;
      hi = sc2a_pkg::CHAR_NONE;
      case (code)
        7'h10: lo = "q";
        7'h11: lo = "w";
        7'h12: lo = "e";
        7'h13: lo = "r";
        7'h14: lo = "t";
        7'h15: lo = "y";
        7'h16: lo = "u";
        7'h17: lo = "i";
        7'h18: lo = "o";
        7'h19: lo = "p";
        7'h1E: lo = "a";
        7'h1F: lo = "s";
        7'h20: lo = "d";
        7'h21: lo = "f";
        7'h22: lo = "g";
        7'h23: lo = "h";
        7'h24: lo = "j";
        7'h25: lo = "k";
        7'h26: lo = "l";
        7'h2C: lo = "z";
        7'h2D: lo = "x";
        7'h2E: lo = "c";
        7'h2F: lo = "v";
        7'h30: lo = "b";
        7'h31: lo = "n";
        7'h32: lo = "m";
        7'h02: begin lo = "1"; hi = "!"; end
        7'h03: begin lo = "2"; hi = "\""; end
        7'h04: begin lo = "3"; hi = "#"; end
        7'h05: begin lo = "4"; hi = "$"; end
        7'h06: begin lo = "5"; hi = "%"; end
        7'h07: begin lo = "6"; hi = "&"; end
        7'h08: begin lo = "7"; hi = "/"; end
        7'h09: begin lo = "8"; hi = "("; end
        7'h0A: begin lo = "9"; hi = ")"; end
        7'h0B: begin lo = "0"; hi = "="; end
        7'h33: begin lo = ","; hi = ";"; end
        7'h34: begin lo = "."; hi = ":"; end
        7'h35: begin lo = "-"; hi = "_"; end
        7'h39: lo = " ";
        7'h0E: lo = 8'h08;
        7'h0F: lo = 8'h09;
        7'h1C: lo = 8'h0A;
        7'h01: lo = 8'h1B;
        7'h2B: lo = 8'h27;
        7'h28: lo = 8'h27;
        7'h53: lo = sc2a_pkg::CHAR_DEL;
        default: lo = sc2a_pkg::CHAR_NONE;
      endcase
      if (hi == sc2a_pkg::CHAR_NONE)
        hi = (lo >= "a" && lo <= "z") ? lo - 8'h20 : lo;
      return shifted ? hi : lo;
    endfunction

    function void note_cmd(input sc2a_pkg::cmd_t c);
      sc2a_pkg::rsp_t r;
      logic [6:0] code;
      logic released;
      logic [7:0] ch;
      r = '0;
      if (c.opcode == sc2a_pkg::OP_READ) begin
        if (typed_chars.size() > 0) begin
          r.char_valid = 1'b1;
          r.char_byte = typed_chars.pop_front();
        end
      end else begin
        code = c.scancode[6:0];
        released = c.scancode[7];
        case (code)
          sc2a_pkg::KEY_LSHIFT, sc2a_pkg::KEY_RSHIFT: shift_on = !released;
          sc2a_pkg::KEY_CTRL: ctrl_on = !released;
          sc2a_pkg::KEY_ALT: alt_on = !released;
          sc2a_pkg::KEY_LMETA: lmeta_on = !released;
          sc2a_pkg::KEY_RMETA: rmeta_on = !released;
          sc2a_pkg::KEY_PREFIX: ;
          default: begin
            ch = char_of(code, shift_on);
            if (ch == sc2a_pkg::CHAR_DEL && ctrl_on && alt_on)
              r.reset_request = 1'b1;
            if (ch != sc2a_pkg::CHAR_NONE && !released) begin
              if (typed_chars.size() < FIFO_DEPTH)
                typed_chars.push_back(ch);
              else
                r.overflow = 1'b1;
            end
          end
        endcase
      end
      r.shift_held = shift_on;
      r.ctrl_held = ctrl_on;
      r.alt_held = alt_on;
      pending_rsp.push_back(r);
    endfunction

    function void check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %h, actual %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_rsp(input sc2a_pkg::rsp_t r);
      sc2a_pkg::rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("result beat with nothing expected: %h", r);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      check_field("char_valid", 8'(want.char_valid), 8'(r.char_valid));
      check_field("char_byte", want.char_byte, r.char_byte);
      check_field("overflow", 8'(want.overflow), 8'(r.overflow));
      check_field("reset_request", 8'(want.reset_request), 8'(r.reset_request));
      check_field("shift_held", 8'(want.shift_held), 8'(r.shift_held));
      check_field("ctrl_held", 8'(want.ctrl_held), 8'(r.ctrl_held));
      check_field("alt_held", 8'(want.alt_held), 8'(r.alt_held));
    endfunction
  endclass

  keymap_tracker sb;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall)
        sb.note_cmd(cmd);
      if (rsp_valid && !rsp_stall)
        sb.check_rsp(rsp);
    end
  end

  // receiver side: random stall bursts, plus one long hold on request
  initial begin : rsp_side
    int unsigned n;
    logic held;
    held = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
      end else begin
        n = $urandom_range(1, 13);
        rsp_stall <= !quiet && ($urandom_range(0, 2) == 0);
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic push_beat(input logic op, input logic [7:0] sc);
    cmd_valid <= 1'b1;
    cmd <= '{opcode: op, scancode: sc};
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int unsigned n);
    cmd_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic idle_until_drained();
    cmd_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic send(input logic op, input logic [7:0] sc);
    if (!quiet && $urandom_range(0, 3) == 0)
      idle_cycles($urandom_range(1, 13));
    push_beat(op, sc);
  endtask

  task automatic press(input logic [6:0] code);
    send(sc2a_pkg::OP_SCAN, {1'b0, code});
  endtask

  task automatic release_key(input logic [6:0] code);
    send(sc2a_pkg::OP_SCAN, {1'b1, code});
  endtask

  task automatic random_beat(input int unsigned read_pct);
    int unsigned r;
    logic [6:0] code;
    r = $urandom_range(0, 99);
    if (r < read_pct) begin
      send(sc2a_pkg::OP_READ, 8'($urandom_range(0, 255)));
    end else if (r < read_pct + 3) begin
      // ctrl-alt-delete, press or release of delete
      press(sc2a_pkg::KEY_CTRL);
      press(sc2a_pkg::KEY_ALT);
      send(sc2a_pkg::OP_SCAN, {$urandom_range(0, 1) == 1, 7'h53});
      release_key(sc2a_pkg::KEY_ALT);
      release_key(sc2a_pkg::KEY_CTRL);
    end else if (r < read_pct + 13) begin
      case ($urandom_range(0, 5))
        0: code = sc2a_pkg::KEY_LSHIFT;
        1: code = sc2a_pkg::KEY_RSHIFT;
        2: code = sc2a_pkg::KEY_CTRL;
        3: code = sc2a_pkg::KEY_ALT;
        4: code = sc2a_pkg::KEY_LMETA;
        default: code = sc2a_pkg::KEY_RMETA;
      endcase
      send(sc2a_pkg::OP_SCAN, {$urandom_range(0, 1) == 1, code});
    end else if (r < read_pct + 18) begin
      send(sc2a_pkg::OP_SCAN, 8'($urandom_range(0, 255)));
    end else begin
      do code = 7'($urandom_range(0, 127));
      while (sb.char_of(code, 1'b0) == sc2a_pkg::CHAR_NONE);
      send(sc2a_pkg::OP_SCAN, {$urandom_range(0, 4) == 0, code});
    end
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned read_pct);
    repeat (count) random_beat(read_pct);
  endtask

  initial begin
    sb = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty read, shift handling, prefix, unknown codes, ctrl-alt-delete, meta
    send(sc2a_pkg::OP_READ, 8'hFF);
    press(7'h1E);
    press(sc2a_pkg::KEY_LSHIFT);
    press(7'h1E);
    release_key(sc2a_pkg::KEY_RSHIFT);
    press(7'h02);
    press(sc2a_pkg::KEY_RSHIFT);
    press(7'h02);
    release_key(sc2a_pkg::KEY_LSHIFT);
    send(sc2a_pkg::OP_SCAN, 8'hE0);
    press(sc2a_pkg::KEY_PREFIX);
    send(sc2a_pkg::OP_SCAN, 8'h00);
    send(sc2a_pkg::OP_SCAN, 8'h7F);
    send(sc2a_pkg::OP_SCAN, 8'hFF);
    release_key(7'h1E);
    press(sc2a_pkg::KEY_CTRL);
    press(sc2a_pkg::KEY_ALT);
    press(7'h53);
    release_key(7'h53);
    release_key(sc2a_pkg::KEY_CTRL);
    release_key(sc2a_pkg::KEY_ALT);
    press(sc2a_pkg::KEY_LMETA);
    release_key(sc2a_pkg::KEY_RMETA);
    send(sc2a_pkg::OP_READ, 8'h00);
    send(sc2a_pkg::OP_READ, 8'hAA);

    random_phase(200, 40);
    idle_until_drained();

    // long receiver hold while beats keep coming
    cmd_valid <= 1'b0;
    hold_req = 1'b1;
    do @(negedge clk); while (!hold_active);
    repeat (40) push_beat(sc2a_pkg::OP_SCAN, {1'b0, 7'h1E});

    random_phase(200, 5);
    random_phase(200, 70);
    quiet = 1'b1;
    random_phase(110, 40);

    idle_until_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
